// File: hdl/athm_pkg.sv
`default_nettype none

package athm_pkg;

    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 48;
    localparam int COUNT_W = 11;

    // Request codes; every other code looks up.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_NULL   = 2'd3
    } status_t;

    // Integer mix constants.
    localparam logic [31:0] MIX_C1  = 32'hed5ad4bb;
    localparam logic [31:0] MIX_C2  = 32'hac4c1b51;
    localparam int          MIX_SH1 = 17;
    localparam int          MIX_SH2 = 11;
    localparam int          MIX_SH3 = 15;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] key;
        logic [SIZE_W-1:0] size;
    } slot_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tbl_ctl_t;

    typedef struct packed {
        status_t           status;
        logic [SIZE_W-1:0] size_out;
        logic              inc;
        logic              dec;
    } tbl_res_t;

endpackage

`default_nettype wire

// File: hdl/athm_req_if.sv
`default_nettype none

interface athm_req_if;
    logic                        valid;
    logic                        ready;
    logic [athm_pkg::REQ_W-1:0]  req_type;
    logic [athm_pkg::ADDR_W-1:0] address;
    logic [athm_pkg::SIZE_W-1:0] alloc_size;

    modport source (output valid, output req_type, output address, output alloc_size,
                    input ready);
    modport sink   (input valid, input req_type, input address, input alloc_size,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/athm_rsp_if.sv
`default_nettype none

interface athm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [athm_pkg::SIZE_W-1:0]  size_out;
    logic [athm_pkg::COUNT_W-1:0] entries_held;

    modport source (output valid, output status, output size_out, output entries_held,
                    input ready);
    modport sink   (input valid, input status, input size_out, input entries_held,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/allocation_tracking_hash_map.sv
// Allocation tracking map: address -> allocation size.
// Input channel req carries req_type (insert/update, remove, lookup), address
// and alloc_size; output channel rsp carries one item per request: status,
// size_out and entries_held. Both are valid/ready; an item moves when both
// are high at a rising edge.
// Each request runs alone: the address is mixed over six steps of a shared
// 32x32 multiplier, reduced to a bucket (a mask for a power-of-two
// NUM_BUCKETS, a reciprocal-multiply division otherwise), then the bucket
// row of WAYS slots is read from the table memory, compared and written
// back in the next cycle. req.ready rises with the result and the next
// item is taken at the following edge.
// A finished result sits in the output register; the block still accepts
// the next item, and holds its table read until the output register is free,
// so a stalled receiver delays the next result and stalls the input behind it.
// After reset the table runs a clearing pass (one row a cycle) during
// which req.ready stays low; the count restarts at zero.
`default_nettype none

module allocation_tracking_hash_map #(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input wire logic clk,
    input wire logic rst_n,
    athm_req_if.sink   req,
    athm_rsp_if.source rsp
);
    import athm_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_WAIT = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Request and result payload.
    logic [REQ_W-1:0]   req_type_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SIZE_W-1:0]  size_reg;
    status_t            out_status_reg;
    logic [SIZE_W-1:0]  out_size_reg;
    logic [COUNT_W-1:0] out_entries_reg;

    logic               in_take;
    logic               out_free;
    logic               hash_done;
    logic [BW-1:0]      bucket;
    tbl_ctl_t           tbl_ctl;
    tbl_res_t           tbl_res;
    logic               tbl_ready;

    athm_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_take),
        .address (req.address),
        .done    (hash_done),
        .bucket  (bucket)
    );

    athm_table #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS),
        .BW          (BW)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .bucket     (bucket),
        .req_type   (req_type_reg),
        .address    (addr_reg),
        .alloc_size (size_reg),
        .res        (tbl_res),
        .ready      (tbl_ready)
    );

    assign req.ready = (state_reg == S_IDLE) && tbl_ready;
    assign in_take   = req.valid && req.ready;

    // The output register is empty by the time the read data comes back.
    assign out_free = !out_valid_reg || rsp.ready;

    assign tbl_ctl.rd_en = (state_reg == S_WAIT) && out_free;
    assign tbl_ctl.wr_en = (state_reg == S_UPD);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cnt_next       = cnt_reg + COUNT_W'(tbl_res.inc) - COUNT_W'(tbl_res.dec);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request on accept, the result on write-back.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg <= req.req_type;
            addr_reg     <= req.address;
            size_reg     <= req.alloc_size;
        end
        if (state_reg == S_UPD)
        begin
            out_status_reg  <= tbl_res.status;
            out_size_reg    <= tbl_res.size_out;
            out_entries_reg <= cnt_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.size_out     = out_size_reg;
    assign rsp.entries_held = out_entries_reg;

    a_upd_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> !out_valid_reg)
        else $error("write-back with the output register still full");

    a_null_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && addr_reg == '0)
        |=> out_valid_reg && out_status_reg == ST_NULL && out_size_reg == '0
            && out_entries_reg == $past(cnt_reg))
        else $error("null address not refused");

    a_count_only_on_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_UPD |=> $stable(cnt_reg))
        else $error("entry count moved outside write-back");

    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("bucket ready with no request waiting for it");

endmodule

`default_nettype wire

// File: hdl/athm_hash.sv
`default_nettype none

module athm_hash #(
    parameter int NUM_BUCKETS = 256,
    parameter int BW          = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [athm_pkg::ADDR_W-1:0] address,
    output logic                             done,
    output logic [BW-1:0]                    bucket
);
    import athm_pkg::*;

    localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    typedef enum logic [4:0] {
        H_IDLE   = 5'b00001,
        H_MUL_LO = 5'b00010,
        H_MUL_HI = 5'b00100,
        H_MIX    = 5'b01000,
        H_RED    = 5'b10000
    } hash_state_t;

    hash_state_t       state_reg, state_next;
    logic              round_reg, round_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] x_reg, x_next;
    logic [63:0]       plo_reg, plo_next;
    logic [31:0]       phi_reg, phi_next;
    logic [BW-1:0]     bucket_reg, bucket_next;

    logic [31:0]       mul_a;
    logic [31:0]       mul_c;
    logic [63:0]       mul_p;
    logic [63:0]       mix_sum;
    logic              red_last;
    logic [BW-1:0]     red_rem;

    // One 32x32 multiplier shared by both rounds, low and high half of x in turn.
    assign mul_a   = (state_reg == H_MUL_HI) ? x_reg[63:32] : x_reg[31:0];
    assign mul_c   = round_reg ? MIX_C2 : MIX_C1;
    assign mul_p   = 64'(mul_a) * 64'(mul_c);
    assign mix_sum = plo_reg + {phi_reg, 32'b0};

    generate
        if (IS_POW2) begin : g_mask
            assign red_last = 1'b1;
            assign red_rem  = x_reg[BW-1:0];
        end else begin : g_div
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_BUCKETS));

            logic [BW-1:0] rem_reg, rem_next;
            logic [2:0]    cnt_reg;
            logic [31:0]   quo_reg;
            logic [31:0]   dividend;
            logic [63:0]   recip_prod;
            logic [31:0]   diff;

            // Sixteen bits per step, most significant first: multiply by the
            // reciprocal for a quotient at most one low and register it, then
            // subtract the product back, correct once and register the remainder.
            always_comb
            begin
                unique case (cnt_reg[2:1])
                    2'd0: dividend = {16'(rem_reg), x_reg[63:48]};
                    2'd1: dividend = {16'(rem_reg), x_reg[47:32]};
                    2'd2: dividend = {16'(rem_reg), x_reg[31:16]};
                    2'd3: dividend = {16'(rem_reg), x_reg[15:0]};
                endcase
                recip_prod = 64'(dividend) * 64'(RECIP);
                diff       = dividend - quo_reg * 32'(NUM_BUCKETS);
                if (diff >= 32'(NUM_BUCKETS))
                begin
                    rem_next = BW'(diff - 32'(NUM_BUCKETS));
                end
                else
                begin
                    rem_next = BW'(diff);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    quo_reg <= '0;
                end
                else if (state_reg == H_RED)
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (!cnt_reg[0])
                    begin
                        quo_reg <= recip_prod[63:32];
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                    end
                end
                else
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
            end

            assign red_last = (cnt_reg == 3'd7);
            assign red_rem  = rem_next;
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        done_next   = 1'b0;
        x_next      = x_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        bucket_next = bucket_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next     = address ^ (address >> MIX_SH1);
                    round_next = 1'b0;
                    state_next = H_MUL_LO;
                end
            end
            H_MUL_LO:
            begin
                plo_next   = mul_p;
                state_next = H_MUL_HI;
            end
            H_MUL_HI:
            begin
                phi_next   = mul_p[31:0];
                state_next = H_MIX;
            end
            H_MIX:
            begin
                if (!round_reg)
                begin
                    x_next     = mix_sum ^ (mix_sum >> MIX_SH2);
                    round_next = 1'b1;
                    state_next = H_MUL_LO;
                end
                else
                begin
                    x_next     = mix_sum ^ (mix_sum >> MIX_SH3);
                    state_next = H_RED;
                end
            end
            H_RED:
            begin
                if (red_last)
                begin
                    bucket_next = red_rem;
                    done_next   = 1'b1;
                    state_next  = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

`default_nettype wire

// File: hdl/athm_table.sv
`default_nettype none

module athm_table #(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4,
    parameter int BW          = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire athm_pkg::tbl_ctl_t          ctl,
    input  wire logic [BW-1:0]               bucket,
    input  wire logic [athm_pkg::REQ_W-1:0]  req_type,
    input  wire logic [athm_pkg::ADDR_W-1:0] address,
    input  wire logic [athm_pkg::SIZE_W-1:0] alloc_size,
    output athm_pkg::tbl_res_t               res,
    output logic                             ready
);
    import athm_pkg::*;

    localparam int WIX = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef slot_t [WAYS-1:0] row_t;

    row_t           bank_mem [NUM_BUCKETS];
    row_t           rd_row_reg;
    row_t           new_row;
    row_t           wr_row;
    logic [BW-1:0]  wr_addr;
    logic           wr_en;

    logic           clr_busy_reg, clr_busy_next;
    logic [BW-1:0]  clr_idx_reg, clr_idx_next;

    logic           hit;
    logic           free;
    logic [WIX-1:0] hit_idx;
    logic [WIX-1:0] free_idx;

    // After reset, a clearing pass zeroes one row a cycle, from row 0 up.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == BW'(NUM_BUCKETS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // Find the first matching way and the first free way of the bucket row.
    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_row_reg[w].valid)
            begin
                if (!hit && rd_row_reg[w].key == address)
                begin
                    hit     = 1'b1;
                    hit_idx = WIX'(w);
                end
            end
            else if (!free)
            begin
                free     = 1'b1;
                free_idx = WIX'(w);
            end
        end
    end

    always_comb
    begin
        new_row      = rd_row_reg;
        res.status   = ST_OK;
        res.size_out = '0;
        res.inc      = 1'b0;
        res.dec      = 1'b0;
        if (address == '0)
        begin
            res.status = ST_NULL;
        end
        else
        begin
            unique case (req_type)
                REQ_INSERT:
                begin
                    if (hit)
                    begin
                        new_row[hit_idx].size = alloc_size;
                    end
                    else if (free)
                    begin
                        new_row[free_idx].valid = 1'b1;
                        new_row[free_idx].key   = address;
                        new_row[free_idx].size  = alloc_size;
                        res.inc                 = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
                REQ_REMOVE:
                begin
                    if (hit)
                    begin
                        new_row[hit_idx].valid = 1'b0;
                        res.dec                = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_ABSENT;
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        res.size_out = rd_row_reg[hit_idx].size;
                    end
                    else
                    begin
                        res.status = ST_ABSENT;
                    end
                end
            endcase
        end
    end

    assign wr_en   = clr_busy_reg | ctl.wr_en;
    assign wr_addr = clr_busy_reg ? clr_idx_reg : bucket;
    assign wr_row  = clr_busy_reg ? row_t'('0) : new_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_row_reg <= bank_mem[bucket];
        end
    end

    assign ready = !clr_busy_reg;

    a_clear_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing pass restarted");

    a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !ctl.rd_en && !ctl.wr_en)
        else $error("row access during clearing pass");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> $past(ctl.rd_en))
        else $error("row written back without a read the cycle before");

    a_inc_dec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> !(res.inc && res.dec))
        else $error("count raised and lowered by one item");

endmodule

`default_nettype wire

// File: sim/tb_allocation_tracking_hash_map.sv
`default_nettype none

module tb_allocation_tracking_hash_map;
    import athm_pkg::*;

    localparam int NUM_BUCKETS = 256;
    localparam int WAYS        = 4;
    localparam int SLOTS       = NUM_BUCKETS * WAYS;

    // Request codes the package leaves unnamed: both of these look up.
    localparam logic [REQ_W-1:0]  REQ_LOOKUP = 2'd2;
    localparam logic [REQ_W-1:0]  REQ_ALIAS  = 2'd3;
    localparam logic [ADDR_W-1:0] NULL_ADDR  = '0;

    // Number of recently used keys kept around for hits on remove/lookup/update.
    localparam int KEY_POOL_DEPTH = 48;
    localparam int HOT_COUNT      = 6;

    typedef struct {
        status_t            status;
        bit [SIZE_W-1:0]    size;
        bit [COUNT_W-1:0]   held;
    } map_result_t;

    // Bucket of an address: xor-shift-multiply mix, products wrap at 64 bits.
    function automatic int unsigned hash_bucket(bit [ADDR_W-1:0] addr);
        bit [63:0] x;
        x = addr;
        x = x ^ (x >> MIX_SH1);
        x = x * 64'(MIX_C1);
        x = x ^ (x >> MIX_SH2);
        x = x * 64'(MIX_C2);
        x = x ^ (x >> MIX_SH3);
        return 32'(x % 64'(NUM_BUCKETS));
    endfunction

    // Mirror of the table; predicts one result per accepted request and
    // checks results against the oldest prediction.
    class map_scoreboard;
        bit [ADDR_W-1:0] slot_key   [SLOTS];
        bit [SIZE_W-1:0] slot_size  [SLOTS];
        bit              slot_valid [SLOTS];
        int unsigned     entry_total;
        map_result_t     results_due[$];
        int unsigned     mismatches;

        function void note_request(bit [REQ_W-1:0] kind, bit [ADDR_W-1:0] addr,
                                   bit [SIZE_W-1:0] size);
            map_result_t r;
            int          base;
            int          hit_slot;
            int          free_slot;
            r.status = ST_OK;
            r.size   = '0;
            if (addr == NULL_ADDR) begin
                r.status = ST_NULL;
            end
            else begin
                base      = int'(hash_bucket(addr)) * WAYS;
                hit_slot  = -1;
                free_slot = -1;
                for (int w = 0; w < WAYS; w++) begin
                    if (slot_valid[base + w]) begin
                        if (hit_slot < 0 && slot_key[base + w] == addr)
                            hit_slot = base + w;
                    end
                    else if (free_slot < 0) begin
                        free_slot = base + w;
                    end
                end
                case (kind)
                    REQ_INSERT: begin
                        if (hit_slot >= 0) begin
                            slot_size[hit_slot] = size;
                        end
                        else if (free_slot >= 0) begin
                            slot_key[free_slot]   = addr;
                            slot_size[free_slot]  = size;
                            slot_valid[free_slot] = 1'b1;
                            entry_total++;
                        end
                        else begin
                            r.status = ST_FULL;
                        end
                    end
                    REQ_REMOVE: begin
                        if (hit_slot >= 0) begin
                            slot_valid[hit_slot] = 1'b0;
                            if (entry_total > 0)
                                entry_total--;
                        end
                        else begin
                            r.status = ST_ABSENT;
                        end
                    end
                    default: begin
                        if (hit_slot >= 0)
                            r.size = slot_size[hit_slot];
                        else
                            r.status = ST_ABSENT;
                    end
                endcase
            end
            r.held = COUNT_W'(entry_total);
            results_due.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [SIZE_W-1:0] size,
                                   logic [COUNT_W-1:0] held);
            map_result_t want;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: status %0d size %h held %0d",
                             status, size, held);
                return;
            end
            want = results_due.pop_front();
            if (status !== want.status || size !== want.size || held !== want.held) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d size %h held %0d, got status %0d size %h held %0d",
                             want.status, want.size, want.held, status, size, held);
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    athm_req_if req_ch ();
    athm_rsp_if rsp_ch ();

    allocation_tracking_hash_map #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    map_scoreboard sb = new();

    // Idle rates in percent for each side, and a receiver hold-off counted
    // down in cycles by the receiver process itself.
    int          send_idle_pct;
    int          recv_idle_pct;
    int          rsp_hold_cycles;

    bit [ADDR_W-1:0] key_pool[$];
    int unsigned     hot_buckets[HOT_COUNT];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Pick an address that lands in bucket b; about NUM_BUCKETS tries on average.
    function automatic bit [ADDR_W-1:0] addr_in_bucket(int unsigned b);
        bit [ADDR_W-1:0] a;
        do
            a = {$urandom, $urandom};
        while (a == NULL_ADDR || hash_bucket(a) != b);
        return a;
    endfunction

    // Sizes: mostly random, with the zero and all-ones extremes mixed in.
    function automatic bit [SIZE_W-1:0] pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 5)
            return '0;
        if (p < 10)
            return '1;
        return SIZE_W'({$urandom, $urandom});
    endfunction

    function automatic void remember_key(bit [ADDR_W-1:0] a);
        if (a == NULL_ADDR)
            return;
        key_pool.push_back(a);
        if (key_pool.size() > KEY_POOL_DEPTH)
            void'(key_pool.pop_front());
    endfunction

    // Offer one request; call at a falling edge, returns at a falling edge.
    // Idle cycles drop valid first; after the handshake the item is noted.
    task automatic send_request(input bit [REQ_W-1:0] kind, input bit [ADDR_W-1:0] addr,
                                input bit [SIZE_W-1:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.address    <= addr;
        req_ch.alloc_size <= size;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, addr, size);
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result has been checked.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random traffic: most requests hit a handful of hot buckets or reuse a
    // recent key, so buckets fill up, updates and removes find their key,
    // and full-bucket refusals are common. The rest is wide-open noise.
    task automatic run_random(input int count);
        bit [REQ_W-1:0]  kind;
        bit [ADDR_W-1:0] addr;
        int              p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(99);
            if (p < 40)
                kind = REQ_INSERT;
            else if (p < 65)
                kind = REQ_REMOVE;
            else if (p < 93)
                kind = REQ_LOOKUP;
            else
                kind = REQ_ALIAS;

            p = $urandom_range(99);
            if (p < 3) begin
                addr = NULL_ADDR;
            end
            else if (p < 50 && key_pool.size() > 0) begin
                addr = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            else if (p < 85) begin
                addr = addr_in_bucket(hot_buckets[$urandom_range(HOT_COUNT - 1)]);
                remember_key(addr);
            end
            else if (p < 87) begin
                addr = '1;
                remember_key(addr);
            end
            else begin
                addr = {$urandom, $urandom};
                remember_key(addr);
            end
            send_request(kind, addr, pick_size());
            // Hold the receiver off for a long stretch once, mid-phase, so
            // the block fills up and stalls its input.
            if (i == 100 && send_idle_pct == 0 && recv_idle_pct == 0)
                rsp_hold_cycles = 300;
        end
    endtask

    // Receiver: check at the rising edge, choose ready at the falling edge.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.size_out, rsp_ch.entries_held);
            @(negedge clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        bit [ADDR_W-1:0] same_bucket[5];
        bit [ADDR_W-1:0] all_ones;
        int unsigned     b0;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_INSERT;
        req_ch.address    = '0;
        req_ch.alloc_size = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        rsp_hold_cycles   = 0;

        for (int i = 0; i < HOT_COUNT; i++)
            hot_buckets[i] = $urandom_range(NUM_BUCKETS - 1);
        b0 = $urandom_range(NUM_BUCKETS - 1);
        for (int i = 0; i < 5; i++) begin
            same_bucket[i] = addr_in_bucket(b0);
            remember_key(same_bucket[i]);
        end
        all_ones = '1;

        // Reset first; the block then clears its table with ready low, which
        // the first handshake simply waits out.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: miss on an empty bucket, fill one bucket past its ways,
        // update in place, remove and refill the lowest free way.
        send_request(REQ_LOOKUP, same_bucket[0], pick_size());
        send_request(REQ_REMOVE, same_bucket[0], pick_size());
        send_request(REQ_INSERT, same_bucket[0], '0);
        send_request(REQ_INSERT, same_bucket[1], '1);
        send_request(REQ_INSERT, same_bucket[2], pick_size());
        send_request(REQ_INSERT, same_bucket[3], pick_size());
        send_request(REQ_INSERT, same_bucket[4], pick_size());
        send_request(REQ_LOOKUP, same_bucket[1], pick_size());
        send_request(REQ_INSERT, same_bucket[1], 48'h5);
        send_request(REQ_ALIAS,  same_bucket[1], pick_size());
        send_request(REQ_REMOVE, same_bucket[1], pick_size());
        send_request(REQ_LOOKUP, same_bucket[1], pick_size());
        send_request(REQ_INSERT, same_bucket[4], pick_size());
        send_request(REQ_LOOKUP, same_bucket[4], pick_size());
        send_request(REQ_LOOKUP, same_bucket[0], pick_size());
        // All-ones key and size, looked up through the spare request code.
        send_request(REQ_INSERT, all_ones, '1);
        send_request(REQ_ALIAS,  all_ones, '0);
        send_request(REQ_REMOVE, all_ones, '1);
        // Null address under every request code.
        send_request(REQ_INSERT, NULL_ADDR, '1);
        send_request(REQ_REMOVE, NULL_ADDR, '1);
        send_request(REQ_LOOKUP, NULL_ADDR, '1);
        send_request(REQ_ALIAS,  NULL_ADDR, '1);
        wait_drained();

        // Phase one: sender mostly busy, receiver mostly stalled.
        send_idle_pct = 7;
        recv_idle_pct = 86;
        run_random(360);
        wait_drained();

        // Phase two: the other way round.
        send_idle_pct = 86;
        recv_idle_pct = 7;
        run_random(360);
        wait_drained();

        // Phase three: no idling, except the one long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(360);
        wait_drained();

        // Let any stray result show up before the verdict.
        repeat (30) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_allocation_tracking_hash_map passed");
        else
            $display("tb_allocation_tracking_hash_map failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #4000000;
        $display("tb_allocation_tracking_hash_map failed");
        $finish;
    end

endmodule

`default_nettype wire
